@@ design/flow_hit_counter_table_macros.svh @@
// Assertion macros shared by the flow hit counter table RTL.
`ifndef FLOW_HIT_COUNTER_TABLE_MACROS_SVH
`define FLOW_HIT_COUNTER_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising edge outside reset.
`define FHCT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define FHCT_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`else

`define FHCT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define FHCT_ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

@@ design/fhct_pkg.sv @@
// Types and constants of the flow hit counter table.
package fhct_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int KEY_W       = ADDR_W + PORT_W;
    localparam int HITS_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 3;

    // Request codes
    localparam logic [FUNC_W-1:0] FN_COUNT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_COUNTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd5;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RESP
    } fhct_state_t;

endpackage

@@ design/fhct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fhct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/flow_hit_counter_table.sv @@
// Flow hit counter table: a count/remove request scans the key RAM one entry per cycle, then
// passes the drain, decide and response states; no new request is taken until it answers.
// A clear sweeps every entry invalid and then answers from the response state.
// An unused request code goes straight to the response state; a held result stalls input.
// Reset (aresetn low, synchronous) starts a sweep that clears every valid bit;
// no request is accepted until it ends.
`include "flow_hit_counter_table_macros.svh"

module flow_hit_counter_table #(
    parameter int ENTRIES = fhct_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fhct_pkg::KEY_W-1:0]  s_tdata,   // [31:0] addr, [47:32] port
    input  logic [fhct_pkg::FUNC_W-1:0] s_tuser,   // [1:0] func
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fhct_pkg::HITS_W-1:0] m_tdata,   // [31:0] hits
    output logic [fhct_pkg::STAT_W-1:0] m_tuser    // [2:0] status
);

    import fhct_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    fhct_state_t state_reg, state_next;

    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [HITS_W-1:0] match_hits_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              chk_vld_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              clr_resp_reg;
    logic [HITS_W-1:0] res_hits_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic              m_tvalid_reg;
    logic [HITS_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0] m_tuser_reg;

    // RAM ports
    logic              key_we;
    logic              hits_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W:0]    key_wdata;
    logic [HITS_W-1:0] hits_wdata;
    logic [KEY_W:0]    key_rdata;
    logic [HITS_W-1:0] hits_rdata;

    logic              s_fire;
    logic              out_load;
    logic              rd_hit;
    logic [HITS_W-1:0] hits_inc;
    logic [HITS_W-1:0] dec_hits;
    logic [STAT_W-1:0] dec_status;

    // key RAM word: {valid, addr, port}
    fhct_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (scan_idx_reg),
        .rdata (key_rdata)
    );

    fhct_ram #(
        .WIDTH (HITS_W),
        .DEPTH (ENTRIES)
    ) u_hits_ram (
        .aclk  (aclk),
        .we    (hits_we),
        .waddr (wr_addr),
        .wdata (hits_wdata),
        .raddr (scan_idx_reg),
        .rdata (hits_rdata)
    );

    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_RESP) && (!m_tvalid_reg || m_tready);
    assign rd_hit   = key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == key_reg);
    assign hits_inc = (match_hits_reg == {HITS_W{1'b1}}) ? match_hits_reg
                                                         : match_hits_reg + HITS_W'(1);

    // Next state
    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        case (state_reg)
            S_SWEEP: begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX) begin
                    scan_idx_next = '0;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                scan_idx_next = '0;
                if (s_fire) begin
                    case (s_tuser)
                        FN_COUNT, FN_REMOVE: state_next = S_SCAN;
                        FN_CLEAR:            state_next = S_SWEEP;
                        default:             state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX) begin
                    scan_idx_next = '0;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE: state_next = S_RESP;
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_SWEEP;
        endcase
    end

    // Outputs: handshake, RAM writes and the decided result
    always_comb begin
        s_tready   = 1'b0;
        key_we     = 1'b0;
        hits_we    = 1'b0;
        wr_addr    = scan_idx_reg;
        key_wdata  = '0;
        hits_wdata = hits_inc;
        dec_hits   = '0;
        dec_status = STAT_NOTFOUND;
        case (state_reg)
            S_SWEEP: begin
                key_we = 1'b1;
            end
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_DECIDE: begin
                if (func_reg == FN_COUNT) begin
                    if (match_found_reg) begin
                        hits_we    = 1'b1;
                        wr_addr    = match_idx_reg;
                        dec_hits   = hits_inc;
                        dec_status = STAT_COUNTED;
                    end else if (free_found_reg) begin
                        key_we     = 1'b1;
                        hits_we    = 1'b1;
                        wr_addr    = free_idx_reg;
                        key_wdata  = {1'b1, key_reg};
                        hits_wdata = HITS_W'(1);
                        dec_hits   = HITS_W'(1);
                        dec_status = STAT_INSERTED;
                    end else begin
                        dec_status = STAT_FULL;
                    end
                end else if (match_found_reg) begin
                    key_we     = 1'b1;
                    wr_addr    = match_idx_reg;
                    key_wdata  = {1'b0, key_reg};
                    dec_status = STAT_REMOVED;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            scan_idx_reg    <= '0;
            chk_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            clr_resp_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= (state_reg == S_SCAN);
            if (s_fire) begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                clr_resp_reg    <= (s_tuser == FN_CLEAR);
            end else if (chk_vld_reg) begin
                if (rd_hit) begin
                    match_found_reg <= 1'b1;
                end
                if (!key_rdata[KEY_W]) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        chk_idx_reg <= scan_idx_reg;
        if (s_fire) begin
            func_reg <= s_tuser;
            key_reg  <= {s_tdata[ADDR_W-1:0], s_tdata[KEY_W-1:ADDR_W]};
            res_hits_reg   <= '0;
            res_status_reg <= (s_tuser == FN_CLEAR) ? STAT_CLEARED : STAT_NOTFOUND;
        end
        // lowest matching entry and lowest free entry
        if (chk_vld_reg && rd_hit && !match_found_reg) begin
            match_idx_reg  <= chk_idx_reg;
            match_hits_reg <= hits_rdata;
        end
        if (chk_vld_reg && !key_rdata[KEY_W] && !free_found_reg) begin
            free_idx_reg <= chk_idx_reg;
        end
        if (state_reg == S_DECIDE) begin
            res_hits_reg   <= dec_hits;
            res_status_reg <= dec_status;
        end
        if (out_load) begin
            m_tdata_reg <= res_hits_reg;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FHCT_ASSERT_IMPL(a_insert_one, aclk, aresetn, m_tvalid && m_tuser == STAT_INSERTED, m_tdata == 1, "inserted flow must report one hit")
    `FHCT_ASSERT_IMPL(a_load_from_resp, aclk, aresetn, $rose(m_tvalid), $past(state_reg == S_RESP), "result loaded outside response state")
    `FHCT_ASSERT_IMPL(a_sweep_invalid, aclk, aresetn, key_we && state_reg == S_SWEEP, !key_wdata[KEY_W], "sweep wrote a valid entry")
    `FHCT_ASSERT_NEVER(a_hits_zero, aclk, aresetn, hits_we && hits_wdata == 0, "hit count written as zero")
    `FHCT_ASSERT_NEVER(a_tready_busy, aclk, aresetn, s_tready && (chk_vld_reg || key_we || hits_we), "request taken while table busy")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the flow hit counter table: directed table, table fill, then random traffic.
`timescale 1ns / 100ps

module testbench;
    import fhct_pkg::*;

    localparam int ENTRIES         = ENTRIES_DEF;
    localparam int POOL_SIZE       = 96;       // more keys than entries so the table fills up
    localparam int RANDOM_ITEMS    = 1040;
    localparam int PRESSURE_AT     = 200;      // results seen before the long receiver hold-off
    localparam int PRESSURE_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 1000000;

    // Request code the block leaves unused
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic [STAT_W-1:0] status;
    } flow_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic              typed;
        logic [HITS_W-1:0] hits;
        logic [STAT_W-1:0] status;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [KEY_W-1:0]  s_tdata;
    logic [FUNC_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [HITS_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    // Shadow copy of the flow table
    logic              slot_valid [ENTRIES];
    logic [KEY_W-1:0]  slot_key   [ENTRIES];
    logic [HITS_W-1:0] slot_hits  [ENTRIES];

    flow_result_t      expected_results [$];
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    logic [PORT_W-1:0] pool_port [POOL_SIZE];

    int error_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    bit no_idle         = 1'b0;

    // Directed requests; typed rows carry an expectation that is plain from the spec
    stim_row_t directed_rows [25] = '{
        '{FN_COUNT,  32'h0000_0000, 16'h0000, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'h0000_0000, 16'h0000, 1'b1, 32'd2, STAT_COUNTED},
        '{FN_COUNT,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'hFFFF_FFFF, 16'h0000, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'h0000_0000, 16'hFFFF, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, 32'd0, STAT_REMOVED},
        '{FN_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, 32'd0, STAT_NOTFOUND},
        '{FN_COUNT,  32'h0000_0000, 16'hFFFF, 1'b0, 32'd0, STAT_COUNTED},
        '{FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0, STAT_NOTFOUND},
        '{FN_COUNT,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'd0, STAT_COUNTED},
        '{FN_COUNT,  32'h0000_0000, 16'h0000, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'h0000_0000, 16'h0000, 1'b0, 32'd0, STAT_COUNTED},
        '{FN_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 32'd0, STAT_REMOVED},
        '{FN_COUNT,  32'hA5A5_A5A5, 16'h5A5A, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'h5A5A_5A5A, 16'hA5A5, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'hA5A5_A5A5, 16'h5A5A, 1'b0, 32'd0, STAT_COUNTED},
        '{FN_REMOVE, 32'h5A5A_5A5A, 16'h5A5A, 1'b1, 32'd0, STAT_NOTFOUND},
        '{FN_CLEAR,  32'h0000_0000, 16'h0000, 1'b1, 32'd0, STAT_CLEARED},
        '{FN_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0, STAT_CLEARED},
        '{FN_REMOVE, 32'hA5A5_A5A5, 16'h5A5A, 1'b1, 32'd0, STAT_NOTFOUND},
        '{FN_COUNT,  32'hA5A5_A5A5, 16'h5A5A, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_UNUSED, 32'h0000_0000, 16'h0000, 1'b1, 32'd0, STAT_NOTFOUND},
        '{FN_COUNT,  32'h0000_0001, 16'h0001, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_COUNT,  32'h8000_0000, 16'h8000, 1'b1, 32'd1, STAT_INSERTED},
        '{FN_CLEAR,  32'h1234_5678, 16'h9ABC, 1'b1, 32'd0, STAT_CLEARED}
    };

    flow_hit_counter_table #(
        .ENTRIES(ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Apply one request to the shadow table and return the result it yields.
    // Saturation is modeled, though counting up to the maximum is out of reach in a run.
    function automatic flow_result_t flow_table_apply(input logic [FUNC_W-1:0] fn,
                                                      input logic [ADDR_W-1:0] a,
                                                      input logic [PORT_W-1:0] p);
        flow_result_t     res;
        logic [KEY_W-1:0] k;
        int               hit_idx;
        int               free_idx;
        k          = {a, p};
        res.hits   = '0;
        res.status = STAT_NOTFOUND;
        hit_idx    = -1;
        free_idx   = -1;
        // lowest-numbered match and lowest-numbered free slot
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_key[i] == k) hit_idx = i;
            if (!slot_valid[i]) free_idx = i;
        end
        case (fn)
            FN_COUNT: begin
                if (hit_idx >= 0) begin
                    if (slot_hits[hit_idx] != '1) slot_hits[hit_idx] = slot_hits[hit_idx] + 1'b1;
                    res.hits   = slot_hits[hit_idx];
                    res.status = STAT_COUNTED;
                end else if (free_idx >= 0) begin
                    slot_valid[free_idx] = 1'b1;
                    slot_key[free_idx]   = k;
                    slot_hits[free_idx]  = 1;
                    res.hits             = 1;
                    res.status           = STAT_INSERTED;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            FN_REMOVE: begin
                if (hit_idx >= 0) begin
                    slot_valid[hit_idx] = 1'b0;
                    res.status          = STAT_REMOVED;
                end
            end
            FN_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
                res.status = STAT_CLEARED;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request after a random gap; on acceptance queue its expected result
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] a,
                                input logic [PORT_W-1:0] p, input logic typed,
                                input logic [HITS_W-1:0] t_hits,
                                input logic [STAT_W-1:0] t_status);
        int           gap;
        int           r;
        flow_result_t res;
        gap = 0;
        if (!no_idle) begin
            r = $urandom_range(99);
            if (r >= 97)      gap = $urandom_range(60, 20);
            else if (r >= 70) gap = $urandom_range(3, 1);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {p, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = flow_table_apply(fn, a, p);
        if (typed) begin
            res.hits   = t_hits;
            res.status = t_status;
        end
        expected_results.push_back(res);
        items_sent++;
    endtask

    // Stimulus
    initial begin
        int          kind;
        int          n;
        int          r;
        int          idx;
        logic [FUNC_W-1:0] fn;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FN_COUNT;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_hits[i]  = '0;
        end
        // key pool; neighbors share one half of the key so both halves get compared
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_addr[i] = (i % 3 == 1) ? pool_addr[i-1] : $urandom;
            pool_port[i] = (i % 3 == 2) ? pool_port[i-1] : PORT_W'($urandom_range(16'hFFFF));
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i])
            send_request(directed_rows[i].fn, directed_rows[i].addr, directed_rows[i].port,
                         directed_rows[i].typed, directed_rows[i].hits, directed_rows[i].status);

        // Fill the table, then hit the full case, free one slot and refill it
        for (int i = 0; i < ENTRIES; i++)
            send_request(FN_COUNT, 32'hF000_0000 | ADDR_W'(i), PORT_W'(i), 1'b0, '0,
                         STAT_COUNTED);
        send_request(FN_COUNT, 32'hDEAD_BEEF, 16'hFFFF, 1'b1, 32'd0, STAT_FULL);
        send_request(FN_COUNT, 32'hF000_0003, 16'd3, 1'b1, 32'd2, STAT_COUNTED);
        send_request(FN_REMOVE, 32'hF000_0011, 16'd17, 1'b1, 32'd0, STAT_REMOVED);
        send_request(FN_COUNT, 32'hDEAD_BEEF, 16'hFFFF, 1'b1, 32'd1, STAT_INSERTED);
        send_request(FN_COUNT, 32'hBEEF_DEAD, 16'hFFFF, 1'b1, 32'd0, STAT_FULL);
        send_request(FN_CLEAR, 32'h0, 16'h0, 1'b1, 32'd0, STAT_CLEARED);

        // Random traffic in sequences
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(4) == 0);
            kind    = $urandom_range(99);
            if (kind < 75) begin
                // well-formed burst on pool keys, sometimes from an empty table
                if ($urandom_range(4) == 0)
                    send_request(FN_CLEAR, $urandom, PORT_W'($urandom_range(16'hFFFF)),
                                 1'b0, '0, STAT_CLEARED);
                n = $urandom_range(40, 10);
                repeat (n) begin
                    r   = $urandom_range(99);
                    idx = $urandom_range(POOL_SIZE - 1);
                    fn  = (r < 78) ? FN_COUNT : (r < 99) ? FN_REMOVE : FN_CLEAR;
                    send_request(fn, pool_addr[idx], pool_port[idx], 1'b0, '0, STAT_COUNTED);
                end
            end else if (kind < 90) begin
                // noise: any code, random or pool keys
                n = $urandom_range(12, 3);
                repeat (n) begin
                    fn  = FUNC_W'($urandom_range(3));
                    idx = $urandom_range(POOL_SIZE - 1);
                    if ($urandom_range(1))
                        send_request(fn, pool_addr[idx], pool_port[idx], 1'b0, '0, STAT_COUNTED);
                    else
                        send_request(fn, $urandom, PORT_W'($urandom_range(16'hFFFF)), 1'b0, '0,
                                     STAT_COUNTED);
                end
            end else begin
                // one hot flow counted many times
                idx = $urandom_range(POOL_SIZE - 1);
                n   = $urandom_range(50, 20);
                repeat (n) send_request(FN_COUNT, pool_addr[idx], pool_port[idx], 1'b0, '0,
                                        STAT_COUNTED);
            end
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        // Drain and let the block settle
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, and checking
    initial begin
        int           stall_left;
        int           r;
        bit           pressure_done;
        flow_result_t exp_res;
        stall_left    = 0;
        pressure_done = 1'b0;
        m_tready      = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: hits %0h status %0d", m_tdata, m_tuser);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata !== exp_res.hits) begin
                        $error("hits mismatch: expected %0h, actual %0h", exp_res.hits, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== exp_res.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, m_tuser);
                        error_count++;
                    end
                end
                results_checked++;
            end
            if (!pressure_done && results_checked == PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 80) begin
                    m_tready <= 1'b1;
                end else begin
                    if (r >= 97)      stall_left = $urandom_range(80, 30) - 1;
                    else if (r >= 92) stall_left = $urandom_range(10, 4) - 1;
                    else              stall_left = $urandom_range(3, 1) - 1;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule
